// ----- hw/rtl/wavm_pkg.sv -----
// wavm_pkg: types and constants shared by the wav-to-mono parser
// no dependencies
package wavm_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;
   localparam logic [31:0] RATE_DEFAULT = 32'd44100;

   localparam logic [1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [1:0] KIND_NO_RIFF  = 2'd1;
   localparam logic [1:0] KIND_NO_WAVE  = 2'd2;
   localparam logic [1:0] KIND_BAD_BITS = 2'd3;

   typedef enum logic [6:0] {
      PH_HEAD = 7'b0000001,
      PH_CHDR = 7'b0000010,
      PH_FMT  = 7'b0000100,
      PH_SKIP = 7'b0001000,
      PH_PAD  = 7'b0010000,
      PH_DATA = 7'b0100000,
      PH_DONE = 7'b1000000
   } phase_type;

   // width codes carried from front to back
   localparam logic [1:0] FMT_U8  = 2'd0;
   localparam logic [1:0] FMT_S16 = 2'd1;
   localparam logic [1:0] FMT_S24 = 2'd2;
   localparam logic [1:0] FMT_F32 = 2'd3;

   // one entry of the queue between front and back
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  fmt;
      logic        is_err;
      logic [1:0]  kind;
      logic        multi;
      logic        last;
      logic [31:0] rate;
   } job_type;

   function automatic logic signed [23:0] float_to_q23(input logic [31:0] w);
      logic [7:0]  ex;
      logic [22:0] man;
      logic [7:0]  sh;
      logic [23:0] mag;
      begin
         ex  = w[30:23];
         man = w[22:0];
         sh  = 8'd127 - ex;
         mag = {1'b1, man} >> sh[4:0];
         if (ex == 8'hFF && man != '0) float_to_q23 = '0;
         else if (ex >= 8'd127) float_to_q23 = w[31] ? 24'sh800000 : 24'sh7FFFFF;
         else if (ex == 8'd0 || sh >= 8'd24) float_to_q23 = '0;
         else float_to_q23 = w[31] ? -$signed(mag) : $signed(mag);
      end
   endfunction

endpackage

// ----- hw/rtl/wavm_front.sv -----
// wavm_front: byte-level chunk walker, frame assembly and framing decisions
// depends on wavm_pkg
module wavm_front
   import wavm_pkg::*;
#(
   parameter int LIMIT_MAX = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [18:0] sample_limit,
   input  logic        in_valid,
   output logic        in_stall,
   input  logic [7:0]  in_byte,
   input  logic        in_start,
   output logic        job_valid,
   output job_type     job,
   output logic [31:0] job_first,
   input  logic        job_full
);
   localparam logic [20:0] LIM_MAX = 21'(LIMIT_MAX);

   phase_type   phase_ff, phase_in;
   logic [31:0] bcnt_ff, bcnt_in, tag_ff, tag_in, len_ff, len_in;
   logic [15:0] chans_ff, chans_in, bits_ff, bits_in, cidx_ff, cidx_in;
   logic [31:0] rate_ff, rate_in, word_ff, word_in, first_ff, first_in;
   logic [19:0] emit_ff, emit_in;
   logic        pad_ff, pad_in;
   // precomputed frame size in bytes, valid in data phase
   logic [31:0] frame_ff, frame_in;

   logic        take;
   logic [19:0] lim;
   logic [2:0]  bps;
   logic [31:0] ord, frame_c;
   logic [7:0]  b;

   assign in_stall = job_full;
   assign take = in_valid && !job_full;
   assign b = in_byte;
   assign lim = ({2'b00, sample_limit} > LIM_MAX) ? LIM_MAX[19:0] : {1'b0, sample_limit};
   assign bps = bits_ff[5:3];
   assign frame_c = 32'(bps) * 32'(chans_ff);

   always_comb begin
      phase_in = phase_ff; bcnt_in = bcnt_ff; tag_in = tag_ff; len_in = len_ff;
      chans_in = chans_ff; bits_in = bits_ff; rate_in = rate_ff; cidx_in = cidx_ff;
      word_in = word_ff; first_in = first_ff; emit_in = emit_ff; pad_in = pad_ff;
      frame_in = frame_ff;
      job_valid = 1'b0;
      job = '0;
      ord = '0;
      if (in_start) begin
         phase_in = PH_HEAD; bcnt_in = '0; tag_in = '0; len_in = '0;
         chans_in = 16'd1; bits_in = 16'd16; rate_in = RATE_DEFAULT; cidx_in = '0;
         word_in = '0; first_in = '0; emit_in = '0; pad_in = 1'b0;
      end
      job.rate = rate_in;
      case (phase_in)
         PH_HEAD: begin
            if (bcnt_in < 32'd4 || bcnt_in >= 32'd8) tag_in = {tag_in[23:0], b};
            if (bcnt_in == 32'd3 && tag_in != TAG_RIFF) begin
               phase_in = PH_DONE;
               job_valid = 1'b1; job.is_err = 1'b1; job.kind = KIND_NO_RIFF;
            end else if (bcnt_in == 32'd11) begin
               if (tag_in != TAG_WAVE) begin
                  phase_in = PH_DONE;
                  job_valid = 1'b1; job.is_err = 1'b1; job.kind = KIND_NO_WAVE;
               end else begin
                  phase_in = PH_CHDR; bcnt_in = '0;
               end
            end else bcnt_in = bcnt_in + 32'd1;
         end
         PH_CHDR: begin
            if (bcnt_in < 32'd4) tag_in = {tag_in[23:0], b};
            else begin
               if (bcnt_in == 32'd4) len_in = '0;
               len_in = len_in | (32'(b) << {bcnt_in[1:0], 3'b000});
            end
            if (bcnt_in == 32'd7) begin
               bcnt_in = '0;
               if (tag_in == TAG_FMT) phase_in = PH_FMT;
               else if (tag_in == TAG_DATA) begin
                  if (bits_in != 16'd8 && bits_in != 16'd16 && bits_in != 16'd24 &&
                      bits_in != 16'd32) begin
                     phase_in = PH_DONE;
                     job_valid = 1'b1; job.is_err = 1'b1; job.kind = KIND_BAD_BITS;
                  end else if (chans_in == 16'd0 || lim == 20'd0 || len_in < frame_c)
                     phase_in = PH_DONE;
                  else begin
                     phase_in = PH_DATA; cidx_in = '0; word_in = '0; emit_in = '0;
                     frame_in = frame_c;
                  end
               end else begin
                  pad_in = len_in[0];
                  phase_in = (len_in != 32'd0) ? PH_SKIP : PH_CHDR;
               end
            end else bcnt_in = bcnt_in + 32'd1;
         end
         PH_FMT: begin
            if (bcnt_in == 32'd2 || bcnt_in == 32'd4 || bcnt_in == 32'd14) word_in = '0;
            if (bcnt_in >= 32'd2 && bcnt_in <= 32'd3) ord = bcnt_in - 32'd2;
            else if (bcnt_in >= 32'd4 && bcnt_in <= 32'd7) ord = bcnt_in - 32'd4;
            else ord = bcnt_in - 32'd14;
            if ((bcnt_in >= 32'd2 && bcnt_in <= 32'd7) || bcnt_in >= 32'd14)
               word_in = word_in | (32'(b) << {ord[1:0], 3'b000});
            if (bcnt_in == 32'd3) chans_in = word_in[15:0];
            else if (bcnt_in == 32'd7) rate_in = word_in;
            if (bcnt_in == 32'd15) begin
               bits_in = word_in[15:0]; word_in = '0; bcnt_in = '0;
               if (len_in > 32'd16) begin
                  pad_in = len_in[0]; len_in = len_in - 32'd16; phase_in = PH_SKIP;
               end else phase_in = PH_CHDR;
            end else bcnt_in = bcnt_in + 32'd1;
         end
         PH_SKIP: begin
            len_in = len_in - 32'd1;
            if (len_in == 32'd0) begin
               phase_in = pad_in ? PH_PAD : PH_CHDR; bcnt_in = '0;
            end
         end
         PH_PAD: begin
            pad_in = 1'b0; phase_in = PH_CHDR; bcnt_in = '0;
         end
         PH_DATA: begin
            word_in = word_in | (32'(b) << {bcnt_in[1:0], 3'b000});
            bcnt_in = bcnt_in + 32'd1;
            if (bcnt_in[2:0] == bps) begin
               bcnt_in = '0;
               if (cidx_in == 16'd0) first_in = word_in;
               cidx_in = cidx_in + 16'd1;
               if (cidx_in >= chans_in) begin
                  cidx_in = '0;
                  len_in = len_in - frame_ff;
                  emit_in = emit_in + 20'd1;
                  job_valid = 1'b1;
                  job.word = word_in;
                  job.multi = chans_in > 16'd1;
                  job.last = (len_in < frame_ff) || (emit_in >= lim);
                  if (job.last) phase_in = PH_DONE;
               end
               word_in = '0;
            end
         end
         default: ;
      endcase
      case (bits_in[5:3])
         3'd1: job.fmt = FMT_U8;
         3'd2: job.fmt = FMT_S16;
         3'd3: job.fmt = FMT_S24;
         default: job.fmt = FMT_F32;
      endcase
   end

   // first channel word travels beside the job
   assign job_first = first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD; bcnt_ff <= '0; tag_ff <= '0; len_ff <= '0;
         chans_ff <= 16'd1; bits_ff <= 16'd16; rate_ff <= RATE_DEFAULT;
         cidx_ff <= '0; word_ff <= '0; first_ff <= '0; emit_ff <= '0; pad_ff <= 1'b0;
         frame_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; bcnt_ff <= bcnt_in; tag_ff <= tag_in; len_ff <= len_in;
         chans_ff <= chans_in; bits_ff <= bits_in; rate_ff <= rate_in;
         cidx_ff <= cidx_in; word_ff <= word_in; first_ff <= first_in;
         emit_ff <= emit_in; pad_ff <= pad_in; frame_ff <= frame_in;
      end
   end
endmodule

// ----- hw/rtl/wavm_queue.sv -----
// wavm_queue: short queue of jobs between front and back
// depends on wavm_pkg
module wavm_queue
   import wavm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   input  logic [31:0] wr_first,
   output logic    full,
   output logic    rd_valid,
   output job_type rd_job,
   output logic [31:0] rd_first,
   input  logic    rd_en
);
   job_type     mem_ff [4];
   logic [31:0] fst_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign rd_valid = cnt_ff != 3'd0;
   assign rd_job = mem_ff[rp_ff];
   assign rd_first = fst_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_job;
         fst_ff[wp_ff] <= wr_first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 2'd1;
         if (rd_en) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr_en) - 3'(rd_en);
      end
   end
endmodule

// ----- hw/rtl/wavm_back.sv -----
// wavm_back: sample conversion, downmix and output register
// depends on wavm_pkg
module wavm_back
   import wavm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   input  logic [31:0] first,
   output logic        job_pop,
   output logic        out_valid,
   input  logic        out_stall,
   output logic signed [23:0] out_sample,
   output logic [31:0] out_rate,
   output logic [1:0]  out_kind,
   output logic        out_last
);
   logic signed [23:0] a, v, m;
   logic signed [24:0] s;
   logic               valid_ff;
   logic signed [23:0] smp_ff;
   logic [31:0]        rate_ff;
   logic [1:0]         kind_ff;
   logic               last_ff;

   function automatic logic signed [23:0] conv(input logic [1:0] f, input logic [31:0] w);
      case (f)
         FMT_U8:  conv = {w[7:0] ^ 8'h80, 16'h0000};
         FMT_S16: conv = {w[15:0], 8'h00};
         FMT_S24: conv = w[23:0];
         default: conv = float_to_q23(w);
      endcase
   endfunction

   assign a = conv(job.fmt, first);
   assign v = conv(job.fmt, job.word);
   assign s = 25'(a) + 25'(v);
   assign m = job.is_err ? 24'sd0 : (job.multi ? s[24:1] : v);

   assign job_pop = job_valid && (!valid_ff || !out_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (job_pop) valid_ff <= 1'b1;
      else if (!out_stall) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         smp_ff <= m; rate_ff <= job.rate;
         kind_ff <= job.is_err ? job.kind : KIND_SAMPLE;
         last_ff <= job.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_sample = smp_ff;
   assign out_rate = rate_ff;
   assign out_kind = kind_ff;
   assign out_last = last_ff;
endmodule

// ----- hw/rtl/wav_pcm_stream_to_mono.sv -----
// wav_pcm_stream_to_mono: top level, wires front, queue and back
// depends on wavm_pkg, wavm_front, wavm_queue, wavm_back
// Takes one WAV byte per cycle while req_stall is low; the chunk walker in the
// front computes its next state combinationally for each byte it accepts. Each result
// passes through a four-entry queue and an output register, so the byte side
// keeps running while a result waits to be taken, until the queue fills.
// The limit register is writable whenever the block is idle; csr_ready is high.
module wav_pcm_stream_to_mono
   import wavm_pkg::*;
#(
   parameter int LIMIT_MAX = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [18:0] csr_sample_limit,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [23:0] rsp_mono_sample,
   output logic [31:0] rsp_sample_rate,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_last_sample
);
   logic [18:0] limit_ff;
   logic        fj_valid, q_full, q_valid, q_pop, take;
   job_type     fj, qj;
   logic [31:0] ffirst, qfirst;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 19'd262144;
      else if (csr_valid) limit_ff <= csr_sample_limit;
   end

   wavm_front #(.LIMIT_MAX(LIMIT_MAX)) u_front (
      .clock, .reset, .sample_limit(limit_ff),
      .in_valid(req_valid), .in_stall(req_stall), .in_byte(req_file_byte),
      .in_start(req_file_start), .job_valid(fj_valid), .job(fj), .job_first(ffirst),
      .job_full(q_full)
   );

   assign take = fj_valid && req_valid && !q_full;

   wavm_queue u_queue (
      .clock, .reset, .wr_en(take), .wr_job(fj), .wr_first(ffirst),
      .full(q_full), .rd_valid(q_valid), .rd_job(qj), .rd_first(qfirst), .rd_en(q_pop)
   );

   wavm_back u_back (
      .clock, .reset, .job_valid(q_valid), .job(qj), .first(qfirst), .job_pop(q_pop),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_sample(rsp_mono_sample),
      .out_rate(rsp_sample_rate), .out_kind(rsp_result_kind), .out_last(rsp_last_sample)
   );
endmodule

// ----- hw/rtl/wavm_checker.sv -----
// wavm_checker: port-level checks for wav_pcm_stream_to_mono
// depends on the top level port list only
module wavm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [23:0] rsp_mono_sample,
   input logic [1:0]  rsp_result_kind,
   input logic        rsp_last_sample
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mono_sample)) else $error("rsp hold");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != 2'd0 |-> rsp_mono_sample == 24'd0) else $error("err sample");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != 2'd0 |-> !rsp_last_sample) else $error("err last");
endmodule

bind wav_pcm_stream_to_mono wavm_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_mono_sample, .rsp_result_kind,
   .rsp_last_sample
);

// ----- dv/wav_pcm_stream_to_mono_chk.sv -----
// wav_pcm_stream_to_mono_chk: watches the byte, result and limit channels of the parser,
// predicts every result from the accepted bytes and compares them field by field
// depends on wavm_pkg
module wav_pcm_stream_to_mono_chk
   import wavm_pkg::*;
#(
   parameter int LIMIT_MAX = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [18:0] csr_sample_limit,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_file_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic signed [23:0] rsp_mono_sample,
   input  logic [31:0] rsp_sample_rate,
   input  logic [1:0]  rsp_result_kind,
   input  logic        rsp_last_sample,
   output int          fail_count,
   output int          pending,
   output int          samples_seen,
   output int          alarms_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [23:0] sample;
      logic [31:0] rate;
      logic [1:0]  kind;
      logic        last;
   } mono_result_type;

   mono_result_type expected_results[$];

   // parser copy
   logic [18:0] limit_reg;
   phase_type   phase;
   logic [31:0] byte_cnt, tag_word, chunk_len, asm_word, rate_val;
   logic [15:0] chans, bits, chan_idx;
   logic [18:0] emitted;
   int          first_val;
   logic        pad_due;

   function automatic void restart_parser();
      phase = PH_HEAD;
      byte_cnt = '0;
      tag_word = '0;
      chunk_len = '0;
      chans = 16'd1;
      bits = 16'd16;
      rate_val = RATE_DEFAULT;
      chan_idx = '0;
      asm_word = '0;
      first_val = 0;
      emitted = '0;
      pad_due = 1'b0;
   endfunction

   function automatic logic [31:0] limit_now();
      return (limit_reg > LIMIT_MAX) ? 32'(LIMIT_MAX) : 32'(limit_reg);
   endfunction

   function automatic int word_to_q23(logic [31:0] w);
      int ex, man, mag;
      case (bits)
         16'd8:  return (int'(w[7:0]) - 128) * 65536;
         16'd16: return int'($signed(w[15:0])) * 256;
         16'd24: return int'($signed(w[23:0]));
         default: begin
            ex  = int'(w[30:23]);
            man = int'(w[22:0]);
            if (ex == 255 && man != 0) return 0;
            if (ex >= 127) return w[31] ? -8388608 : 8388607;
            if (ex == 0 || 127 - ex >= 24) return 0;
            mag = int'({1'b1, w[22:0]} >> (127 - ex));
            return w[31] ? -mag : mag;
         end
      endcase
   endfunction

   function automatic bit chunk_header_end(ref mono_result_type r);
      logic [31:0] frame;
      byte_cnt = '0;
      if (tag_word == TAG_FMT) begin
         phase = PH_FMT;
         return 0;
      end
      if (tag_word == TAG_DATA) begin
         if (bits != 8 && bits != 16 && bits != 24 && bits != 32) begin
            phase = PH_DONE;
            r.kind = KIND_BAD_BITS;
            return 1;
         end
         frame = 32'(bits / 8) * 32'(chans);
         if (chans == 0 || limit_now() == 0 || chunk_len < frame) begin
            phase = PH_DONE;
            return 0;
         end
         phase = PH_DATA;
         chan_idx = '0;
         asm_word = '0;
         emitted = '0;
         return 0;
      end
      pad_due = chunk_len[0];
      phase = (chunk_len != 0) ? PH_SKIP : PH_CHDR;
      return 0;
   endfunction

   // one byte through the parser, returns 1 when it completes a result
   function automatic bit parse_byte(logic [7:0] b, logic start, ref mono_result_type r);
      logic [31:0] bps, frame;
      int v, m;
      if (start) restart_parser();
      r.sample = '0;
      r.rate = rate_val;
      r.kind = KIND_SAMPLE;
      r.last = 1'b0;
      case (phase)
         PH_HEAD: begin
            if (byte_cnt < 4 || byte_cnt >= 8) tag_word = {tag_word[23:0], b};
            if (byte_cnt == 3 && tag_word != TAG_RIFF) begin
               phase = PH_DONE;
               r.kind = KIND_NO_RIFF;
               return 1;
            end
            if (byte_cnt == 11) begin
               if (tag_word != TAG_WAVE) begin
                  phase = PH_DONE;
                  r.kind = KIND_NO_WAVE;
                  return 1;
               end
               phase = PH_CHDR;
               byte_cnt = '0;
               return 0;
            end
            byte_cnt++;
            return 0;
         end
         PH_CHDR: begin
            if (byte_cnt < 4) tag_word = {tag_word[23:0], b};
            else begin
               if (byte_cnt == 4) chunk_len = '0;
               chunk_len |= 32'(b) << (8 * (byte_cnt - 4));
            end
            if (byte_cnt == 7) return chunk_header_end(r);
            byte_cnt++;
            return 0;
         end
         PH_FMT: begin
            if (byte_cnt == 2 || byte_cnt == 4 || byte_cnt == 14) asm_word = '0;
            if (byte_cnt >= 2 && byte_cnt <= 3) asm_word |= 32'(b) << (8 * (byte_cnt - 2));
            else if (byte_cnt >= 4 && byte_cnt <= 7)
               asm_word |= 32'(b) << (8 * (byte_cnt - 4));
            else if (byte_cnt >= 14) asm_word |= 32'(b) << (8 * (byte_cnt - 14));
            if (byte_cnt == 3) chans = asm_word[15:0];
            else if (byte_cnt == 7) rate_val = asm_word;
            else if (byte_cnt == 15) begin
               bits = asm_word[15:0];
               asm_word = '0;
               byte_cnt = '0;
               if (chunk_len > 16) begin
                  pad_due = chunk_len[0];
                  chunk_len -= 16;
                  phase = PH_SKIP;
               end else begin
                  phase = PH_CHDR;
               end
               return 0;
            end
            byte_cnt++;
            return 0;
         end
         PH_SKIP: begin
            chunk_len--;
            if (chunk_len == 0) begin
               phase = pad_due ? PH_PAD : PH_CHDR;
               byte_cnt = '0;
            end
            return 0;
         end
         PH_PAD: begin
            pad_due = 1'b0;
            phase = PH_CHDR;
            byte_cnt = '0;
            return 0;
         end
         PH_DATA: begin
            bps = 32'(bits / 8);
            asm_word |= 32'(b) << (8 * (byte_cnt & 3));
            byte_cnt++;
            if (byte_cnt < bps) return 0;
            v = word_to_q23(asm_word);
            byte_cnt = '0;
            asm_word = '0;
            if (chan_idx == 0) first_val = v;
            chan_idx++;
            if (chan_idx < chans) return 0;
            chan_idx = '0;
            // floor average of first and last channel
            m = (chans > 1) ? ((first_val + v) >>> 1) : v;
            frame = bps * 32'(chans);
            chunk_len -= frame;
            emitted++;
            r.last = (chunk_len < frame || 32'(emitted) >= limit_now());
            if (r.last) phase = PH_DONE;
            r.sample = m[23:0];
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      samples_seen = 0;
      alarms_seen = 0;
      limit_reg = 19'd262144;
      restart_parser();
   end

   always @(posedge clock) begin
      mono_result_type r, want;
      if (reset) begin
         limit_reg = 19'd262144;
         restart_parser();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_sample_limit;
         if (req_valid && !req_stall) begin
            if (parse_byte(req_file_byte, req_file_start, r)) expected_results.push_back(r);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("result with none expected", 0, {30'd0, rsp_result_kind});
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind == KIND_SAMPLE) samples_seen++;
               else alarms_seen++;
               if (rsp_mono_sample !== want.sample) report("mono_sample", want.sample,
                  rsp_mono_sample);
               if (rsp_sample_rate !== want.rate) report("sample_rate", want.rate,
                  rsp_sample_rate);
               if (rsp_result_kind !== want.kind) report("result_kind", want.kind,
                  rsp_result_kind);
               if (rsp_last_sample !== want.last) report("last_sample", want.last,
                  rsp_last_sample);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- dv/wav_pcm_stream_to_mono_tb.sv -----
// wav_pcm_stream_to_mono_tb: builds WAV files byte by byte and feeds them to the parser
// under random idling, walks the limit register through its range and gives the verdict
// depends on wavm_pkg, wav_pcm_stream_to_mono, wav_pcm_stream_to_mono_chk
module wav_pcm_stream_to_mono_tb;
   import wavm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 600000;
   localparam logic [31:0] TAG_JUNK = 32'h4A554E4B;

   logic clock = 1'b0;
   logic reset, csr_valid, csr_ready, req_valid, req_stall, req_file_start;
   logic rsp_valid, rsp_stall, rsp_last_sample;
   logic [18:0] csr_sample_limit;
   logic [7:0]  req_file_byte;
   logic signed [23:0] rsp_mono_sample;
   logic [31:0] rsp_sample_rate;
   logic [1:0]  rsp_result_kind;
   int fail_count, pending, samples_seen, alarms_seen;
   int cycles = 0, bytes_sent = 0, files_sent = 0;
   bit quiet = 0, hold_long = 0;

   logic [7:0]  file_q[$];
   logic [31:0] fixed_words[$];

   always #6 clock = ~clock;

   wav_pcm_stream_to_mono u_dut (.*);

   wav_pcm_stream_to_mono_chk u_chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("wav_pcm_stream_to_mono_tb NOT OK");
         $finish;
      end
   end

   // result side: short random stalls, one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_long = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic put8(logic [7:0] v);
      file_q.push_back(v);
   endtask

   task automatic put_le(logic [31:0] v, int nbytes);
      for (int i = 0; i < nbytes; i++) put8(v[8*i +: 8]);
   endtask

   task automatic put_tag(logic [31:0] t);
      for (int i = 3; i >= 0; i--) put8(t[8*i +: 8]);
   endtask

   function automatic logic [31:0] sample_word(int bits);
      logic [31:0] w;
      int pick;
      w = $urandom;
      pick = $urandom_range(0, 7);
      if (bits == 32) begin
         // steer exponents around the interesting range
         case (pick)
            0: w[30:23] = 8'hFF;
            1: w[30:23] = 8'h00;
            2: w[30:23] = 8'(102 + $urandom_range(0, 3));
            3: w[22:0] = '0;
            default: w[30:23] = 8'($urandom_range(100, 130));
         endcase
      end else if (pick == 0) begin
         w = 32'd1 << (bits - 1);
      end else if (pick == 1) begin
         w = (32'd1 << (bits - 1)) - 1;
      end
      return w;
   endfunction

   task automatic make_file(int ch, int bits, logic [31:0] rate, int fmt_len, bit has_fmt,
                            int junk_len, int frames, int extra);
      int bps;
      logic [31:0] w;
      file_q.delete();
      // odd widths stop the parser at the data header, so keep their body short
      bps = (bits % 8 != 0 || bits / 8 == 0 || bits > 32) ? 1 : bits / 8;
      put_tag(TAG_RIFF);
      put_le($urandom, 4);
      put_tag(TAG_WAVE);
      if (junk_len >= 0) begin
         put_tag(TAG_JUNK);
         put_le(junk_len, 4);
         for (int i = 0; i < junk_len + (junk_len % 2); i++) put8(8'($urandom));
      end
      if (has_fmt) begin
         put_tag(TAG_FMT);
         put_le(fmt_len, 4);
         put_le(1, 2);
         put_le(ch, 2);
         put_le(rate, 4);
         put_le($urandom, 4);
         put_le($urandom, 2);
         put_le(bits, 2);
         // a short fmt still carries its 16 field bytes
         if (fmt_len > 16)
            for (int i = 16; i < fmt_len + (fmt_len % 2); i++) put8(8'($urandom));
      end
      put_tag(TAG_DATA);
      put_le(frames * ch * bps + extra, 4);
      for (int i = 0; i < frames * ch; i++) begin
         w = (fixed_words.size() != 0) ? fixed_words.pop_front() : sample_word(bits);
         put_le(w, bps);
      end
      for (int i = 0; i < extra; i++) put8(8'($urandom));
      fixed_words.delete();
   endtask

   task automatic rand_file();
      int k, ch, bits, fmt_len, junk, idx;
      k = $urandom_range(0, 99);
      if (k < 5) begin
         file_q.delete();
         if (k < 2) put_tag(TAG_RIFF);
         repeat ($urandom_range(1, 20)) put8(8'($urandom));
         return;
      end
      ch = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: bits = 0;
            1: bits = 12;
            2: bits = 40;
            default: bits = $urandom_range(0, 65535);
         endcase
      end else begin
         bits = 8 * $urandom_range(1, 4);
      end
      case ($urandom_range(0, 9))
         0: fmt_len = 14;
         1: fmt_len = 17;
         2: fmt_len = 18;
         3: fmt_len = 21;
         default: fmt_len = 16;
      endcase
      junk = ($urandom_range(0, 9) < 6) ? -1 : $urandom_range(0, 5);
      make_file(ch, bits, $urandom, fmt_len, $urandom_range(0, 11) != 0, junk,
                $urandom_range(0, 10), $urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) begin
         idx = $urandom_range(0, 7);
         if (idx >= 4) idx += 4;
         file_q[idx] ^= 8'(1 << $urandom_range(0, 7));
      end
   endtask

   task automatic send_byte(logic [7:0] b, logic start);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_file_byte <= b;
      req_file_start <= start;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   // stop offering items until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_file(int pause_at);
      for (int i = 0; i < file_q.size(); i++) begin
         send_byte(file_q[i], i == 0);
         if (i == pause_at) drain();
      end
      files_sent++;
   endtask

   task automatic write_limit(logic [18:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_sample_limit <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int budget);
      int stop_at;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         rand_file();
         send_file(-1);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_sample_limit = '0;
      req_valid = 1'b0;
      req_file_byte = '0;
      req_file_start = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: extremes of each width, float specials, error paths
      write_limit(19'd262144);
      fixed_words = '{32'h00, 32'hFF, 32'h80};
      make_file(1, 8, 32'd8000, 16, 1, -1, 3, 0);
      send_file(-1);
      fixed_words = '{32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'h0000};
      make_file(2, 16, 32'hFFFFFFFF, 18, 1, 3, 3, 1);
      send_file(-1);
      fixed_words = '{32'h800000, 32'h0, 32'h7FFFFF, 32'hFFFFFF, 32'h1, 32'h800000};
      make_file(3, 24, 32'd0, 16, 1, 0, 2, 0);
      send_file(-1);
      fixed_words = '{32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h3F800000,
                      32'hBF800000, 32'h00000001, 32'h33FFFFFF, 32'h34000000,
                      32'h3F7FFFFF, 32'hB4000000};
      make_file(2, 32, 32'd48000, 16, 1, -1, 5, 0);
      send_file(-1);
      make_file(1, 12, 32'd1, 16, 1, -1, 1, 0);
      send_file(-1);
      make_file(1, 16, 32'd1, 16, 0, 1, 2, 0);
      send_file(-1);
      make_file(0, 16, 32'd1, 16, 1, -1, 2, 0);
      send_file(-1);
      make_file(1, 8, 32'd1, 16, 1, -1, 1, 0);
      file_q[3] = 8'h58;
      send_file(-1);
      make_file(1, 8, 32'd1, 16, 1, -1, 1, 0);
      file_q[11] = 8'h00;
      send_file(-1);

      write_limit(19'd1);
      random_phase(150);
      write_limit(19'd3);
      rand_file();
      send_file(file_q.size() / 2);
      random_phase(150);

      write_limit(19'h7FFFF);
      hold_long = 1;
      make_file(1, 8, $urandom, 16, 1, -1, 60, 0);
      send_file(-1);
      random_phase(250);

      write_limit(19'd0);
      random_phase(60);
      write_limit(19'd2);
      random_phase(150);

      write_limit(19'd262144);
      random_phase(100);
      quiet = 1;
      random_phase(150);

      drain();
      $display("covered %0d bytes in %0d files at limits 0 to 524287", bytes_sent,
               files_sent);
      $display("checked %0d samples and %0d error results", samples_seen, alarms_seen);
      if (fail_count == 0) $display("wav_pcm_stream_to_mono_tb OK");
      else $display("wav_pcm_stream_to_mono_tb NOT OK");
      $finish;
   end

endmodule
